// ===== rtl/rpu_pkg.sv =====
// Shared types, constants and functions of the raw pixel unpacker.
package rpu_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [15:0] WIDTH_RST  = 16'd640;
    localparam logic [15:0] HEIGHT_RST = 16'd480;

    typedef enum logic [3:0] {
        FMT_BW1    = 4'd0,
        FMT_BW2    = 4'd1,
        FMT_BW4    = 4'd2,
        FMT_BW8    = 4'd3,
        FMT_BW16   = 4'd4,
        FMT_BWA8   = 4'd5,
        FMT_BWA16  = 4'd6,
        FMT_R8     = 4'd7,
        FMT_R16    = 4'd8,
        FMT_RG8    = 4'd9,
        FMT_RG16   = 4'd10,
        FMT_RGB8   = 4'd11,
        FMT_RGB16  = 4'd12,
        FMT_RGBA8  = 4'd13,
        FMT_RGBA16 = 4'd14
    } t_fmt;

    typedef struct packed {
        t_fmt        fmt;
        logic [63:0] word;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
    } t_geom;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] column;
        logic [15:0] row;
        logic        frame_end;
        logic        last;
    } t_pixel;

    function automatic logic [3:0] pixel_bytes(input t_fmt f);
        logic [3:0] n;
        n = 4'd1;
        unique case (f) inside
            FMT_BW8, FMT_R8:                         n = 4'd1;
            FMT_BW16, FMT_BWA8, FMT_R16, FMT_RG8:    n = 4'd2;
            FMT_BWA16, FMT_RG16, FMT_RGBA8:          n = 4'd4;
            FMT_RGB8:                                n = 4'd3;
            FMT_RGB16:                               n = 4'd6;
            FMT_RGBA16:                              n = 4'd8;
            default:                                 n = 4'd1;
        endcase
        return n;
    endfunction

    // round(v / 257) as floor((v + 128) / 257), reciprocal 0xFF01 / 2^24
    function automatic logic [7:0] scale16(input logic [15:0] v);
        logic [16:0] x;
        logic [32:0] p;
        x = {1'b0, v} + 17'd128;
        p = 33'(x) * 33'(17'd65281);
        return p[31:24];
    endfunction

endpackage

// ===== rtl/rpu_queue.sv =====
// Small first-in first-out queue of work items between front and back.
module rpu_queue #(
    parameter int WIDTH = rpu_pkg::ITEM_W,
    parameter int DEPTH = rpu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/rpu_front.sv =====
// Front end: configuration registers, byte gathering and work item issue.
module rpu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_push,
    input  logic [7:0]        i_data_byte,
    input  logic              i_q_full,
    output logic              o_item_valid,
    output rpu_pkg::t_item    o_item,
    output rpu_pkg::t_geom    o_geom,
    output logic              o_clear
);

    rpu_pkg::t_fmt r_fmt, n_fmt;
    logic [15:0]   r_width, n_width;
    logic [15:0]   r_height, n_height;
    logic [55:0]   r_gather, n_gather;
    logic [2:0]    r_held, n_held;
    logic          take;
    logic          is_sub;
    logic [3:0]    need;

    assign take    = i_push && !i_q_full;
    assign o_clear = i_cfg_we && (i_cfg_index == rpu_pkg::REG_FORMAT ||
                                  i_cfg_index == rpu_pkg::REG_WIDTH  ||
                                  i_cfg_index == rpu_pkg::REG_HEIGHT);
    assign is_sub  = (r_fmt == rpu_pkg::FMT_BW1) || (r_fmt == rpu_pkg::FMT_BW2) ||
                     (r_fmt == rpu_pkg::FMT_BW4);
    assign need    = rpu_pkg::pixel_bytes(r_fmt);
    assign o_geom  = '{width: r_width, height: r_height};

    always_comb begin
        n_fmt        = r_fmt;
        n_width      = r_width;
        n_height     = r_height;
        n_gather     = r_gather;
        n_held       = r_held;
        o_item_valid = 1'b0;
        o_item.fmt   = r_fmt;
        o_item.word  = {8'd0, r_gather} | (64'(i_data_byte) << {r_held, 3'b000});
        if (o_clear) begin
            n_gather = '0;
            n_held   = '0;
            if (i_cfg_index == rpu_pkg::REG_FORMAT) begin
                n_fmt = rpu_pkg::t_fmt'(i_cfg_data[3:0]);
            end else if (i_cfg_index == rpu_pkg::REG_WIDTH) begin
                n_width = i_cfg_data;
            end else begin
                n_height = i_cfg_data;
            end
        end else if (take) begin
            if (is_sub) begin
                o_item_valid = 1'b1;
                o_item.word  = 64'(i_data_byte);
            end else if (r_fmt <= rpu_pkg::FMT_RGBA16) begin
                if ({1'b0, r_held} + 4'd1 < need) begin
                    n_gather = r_gather | (56'(i_data_byte) << {r_held, 3'b000});
                    n_held   = r_held + 3'd1;
                end else begin
                    o_item_valid = 1'b1;
                    n_gather     = '0;
                    n_held       = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= rpu_pkg::FMT_RGBA8;
            r_width  <= rpu_pkg::WIDTH_RST;
            r_height <= rpu_pkg::HEIGHT_RST;
            r_gather <= '0;
            r_held   <= '0;
        end else begin
            r_fmt    <= n_fmt;
            r_width  <= n_width;
            r_height <= n_height;
            r_gather <= n_gather;
            r_held   <= n_held;
        end
    end

endmodule

// ===== rtl/rpu_back.sv =====
// Back end: pixel expansion, channel scaling, position tracking, output register.
module rpu_back #(
    parameter int COORD_BITS = rpu_pkg::COORD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  rpu_pkg::t_geom   i_geom,
    input  logic             i_item_valid,
    input  rpu_pkg::t_item   i_item,
    output logic             o_item_take,
    input  logic             i_pop,
    output logic             o_valid,
    output rpu_pkg::t_pixel  o_pixel
);

    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [2:0]            r_pos, n_pos;
    logic                  r_ov, n_ov;
    rpu_pkg::t_pixel       r_pix, n_pix;

    logic [COORD_BITS-1:0] col_max;
    logic [COORD_BITS-1:0] row_max;
    logic                  emit;
    logic                  is_sub;
    logic                  sub_last;
    logic                  col_last;
    logic                  fend;
    logic                  done;
    logic [2:0]            amt;
    logic [7:0]            shifted;
    logic [7:0]            grey;
    logic [63:0]           w;
    logic [7:0]            s0, s1, s2, s3;
    logic [7:0]            ch_r, ch_g, ch_b, ch_a;

    function automatic logic [COORD_BITS-1:0] last_index(input logic [15:0] v);
        logic [15:0] vm;
        logic [COORD_BITS-1:0] res;
        vm = v - 16'd1;
        if (v == 16'd0) begin
            res = '0;
        end else if ((17'(vm) >> COORD_BITS) != 17'd0) begin
            res = '1;
        end else begin
            res = vm[COORD_BITS-1:0];
        end
        return res;
    endfunction

    assign col_max  = last_index(i_geom.width);
    assign row_max  = last_index(i_geom.height);
    assign emit     = i_item_valid && (!r_ov || i_pop);
    assign is_sub   = (i_item.fmt == rpu_pkg::FMT_BW1) || (i_item.fmt == rpu_pkg::FMT_BW2) ||
                      (i_item.fmt == rpu_pkg::FMT_BW4);
    assign amt      = 3'({2'b00, r_pos} << i_item.fmt[1:0]);
    assign sub_last = (r_pos == 3'(3'd7 >> i_item.fmt[1:0]));
    assign col_last = (r_col >= col_max);
    assign fend     = col_last && (r_row >= row_max);
    assign done     = !is_sub || sub_last || fend;
    assign o_item_take = emit && done;
    assign w        = i_item.word;
    assign shifted  = w[7:0] >> amt;
    assign s0       = rpu_pkg::scale16(w[15:0]);
    assign s1       = rpu_pkg::scale16(w[31:16]);
    assign s2       = rpu_pkg::scale16(w[47:32]);
    assign s3       = rpu_pkg::scale16(w[63:48]);

    always_comb begin
        case (i_item.fmt)
            rpu_pkg::FMT_BW1: grey = {8{shifted[0]}};
            rpu_pkg::FMT_BW2: grey = {4{shifted[1:0]}};
            default:          grey = {2{shifted[3:0]}};
        endcase
    end

    always_comb begin
        ch_r = 8'd0;
        ch_g = 8'd0;
        ch_b = 8'd0;
        ch_a = 8'd255;
        unique case (i_item.fmt) inside
            rpu_pkg::FMT_BW1, rpu_pkg::FMT_BW2, rpu_pkg::FMT_BW4: begin
                ch_r = grey; ch_g = grey; ch_b = grey;
            end
            rpu_pkg::FMT_BW8: begin
                ch_r = w[7:0]; ch_g = w[7:0]; ch_b = w[7:0];
            end
            rpu_pkg::FMT_BW16: begin
                ch_r = s0; ch_g = s0; ch_b = s0;
            end
            rpu_pkg::FMT_BWA8: begin
                ch_r = w[7:0]; ch_g = w[7:0]; ch_b = w[7:0]; ch_a = w[15:8];
            end
            rpu_pkg::FMT_BWA16: begin
                ch_r = s0; ch_g = s0; ch_b = s0; ch_a = s1;
            end
            rpu_pkg::FMT_R8:  ch_r = w[7:0];
            rpu_pkg::FMT_R16: ch_r = s0;
            rpu_pkg::FMT_RG8: begin
                ch_r = w[7:0]; ch_g = w[15:8];
            end
            rpu_pkg::FMT_RG16: begin
                ch_r = s0; ch_g = s1;
            end
            rpu_pkg::FMT_RGB8: begin
                ch_r = w[7:0]; ch_g = w[15:8]; ch_b = w[23:16];
            end
            rpu_pkg::FMT_RGB16: begin
                ch_r = s0; ch_g = s1; ch_b = s2;
            end
            rpu_pkg::FMT_RGBA8: begin
                ch_r = w[7:0]; ch_g = w[15:8]; ch_b = w[23:16]; ch_a = w[31:24];
            end
            default: begin
                ch_r = s0; ch_g = s1; ch_b = s2; ch_a = s3;
            end
        endcase
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_pos = r_pos;
        n_ov  = r_ov;
        n_pix = r_pix;
        if (i_clear) begin
            n_col = '0;
            n_row = '0;
            n_pos = '0;
        end else if (emit) begin
            n_ov            = 1'b1;
            n_pix.red       = ch_r;
            n_pix.green     = ch_g;
            n_pix.blue      = ch_b;
            n_pix.alpha     = ch_a;
            n_pix.column    = 16'(r_col);
            n_pix.row       = 16'(r_row);
            n_pix.frame_end = fend;
            n_pix.last      = done;
            n_pos           = done ? 3'd0 : r_pos + 3'd1;
            if (col_last) begin
                n_col = '0;
                n_row = fend ? '0 : r_row + COORD_BITS'(1);
            end else begin
                n_col = r_col + COORD_BITS'(1);
            end
        end else if (i_pop) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_pos <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_pos <= n_pos;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

    assign o_valid = r_ov;
    assign o_pixel = r_pix;

endmodule

// ===== rtl/raw_pixel_unpacker_to_rgba8_top.sv =====
// Top level of the raw pixel unpacker: packed raw bytes in, RGBA8 pixels out.
//
// Bytes go in through a queue-style port (push/full) and RGBA8 pixels come out
// through another (empty/pop), each pixel with its column, row, end-of-frame
// and last-of-byte flags. The front end takes one byte per cycle whenever the
// work queue has room, gathering multi-byte pixels; the back end emits one
// pixel per cycle, while the output register is empty or popped, from the
// head of the work queue into that register. A byte of a 1-, 2- or 4-bit grey
// format yields 8, 4 or 2 pixels and holds the back end until they are out
// (fewer at a frame end); every other format yields at most one pixel per byte,
// so bytes stream at one per cycle while the output is popped. Configuration
// writes clear the gather state and the pixel position; write them only while
// no work is pending.
module raw_pixel_unpacker_to_rgba8_top #(
    parameter int COORD_BITS  = rpu_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = rpu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [15:0] o_column,
    output logic [15:0] o_row,
    output logic        o_frame_end,
    output logic        o_last
);

    logic            fr_valid;
    rpu_pkg::t_item  fr_item;
    rpu_pkg::t_geom  geom;
    logic            clear;
    logic            q_full;
    logic            q_empty;
    rpu_pkg::t_item  q_item;
    logic            q_take;
    logic            out_valid;
    rpu_pkg::t_pixel pix;

    rpu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .i_data_byte  (i_data_byte),
        .i_q_full     (q_full),
        .o_item_valid (fr_valid),
        .o_item       (fr_item),
        .o_geom       (geom),
        .o_clear      (clear)
    );

    rpu_queue #(
        .WIDTH (rpu_pkg::ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_data  (fr_item),
        .o_full  (q_full),
        .i_pop   (q_take),
        .o_data  (q_item),
        .o_empty (q_empty)
    );

    rpu_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (clear),
        .i_geom       (geom),
        .i_item_valid (!q_empty),
        .i_item       (q_item),
        .o_item_take  (q_take),
        .i_pop        (pop),
        .o_valid      (out_valid),
        .o_pixel      (pix)
    );

    assign full        = q_full;
    assign empty       = !out_valid;
    assign o_red       = pix.red;
    assign o_green     = pix.green;
    assign o_blue      = pix.blue;
    assign o_alpha     = pix.alpha;
    assign o_column    = pix.column;
    assign o_row       = pix.row;
    assign o_frame_end = pix.frame_end;
    assign o_last      = pix.last;

endmodule
